// ===== hdl/triangular_fir_smoother_top_macros.svh =====
// Assertion macros used by the checker of the triangular FIR smoother.
`ifndef TRIANGULAR_FIR_SMOOTHER_TOP_MACROS_SVH
`define TRIANGULAR_FIR_SMOOTHER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tfs_pkg.sv =====
// Shared constants of the triangular FIR smoother.
`default_nettype none

package tfs_pkg;

    localparam int HALF_WIDTH_BITS = 4;
    localparam logic [HALF_WIDTH_BITS-1:0] HALF_WIDTH_RESET = 4'd1;

endpackage

`default_nettype wire

// ===== hdl/tfs_in_if.sv =====
// Input stream channel: one sample and its end-of-frame flag per transfer.
`default_nettype none

interface tfs_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          frame_end;

    modport source (output valid, output sample_in, output frame_end, input ready);
    modport sink   (input valid, input sample_in, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== hdl/tfs_out_if.sv =====
// Output stream channel: one result sample and its last-of-frame flag per transfer.
`default_nettype none

interface tfs_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          last_out;

    modport source (output valid, output sample_out, output last_out, input ready);
    modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/triangular_fir_smoother_top.sv =====
// Triangular FIR smoother. Samples of a frame enter a circular history memory with one
// write and one registered read port. With n = half_width, each output lags its input by
// n samples; the first and last n samples of a frame pass through, and a frame shorter
// than 2n+1 passes through unchanged. A smoothed sample reads its 2n+1 neighbors one per
// cycle through the read port, weights them 1..n+1..1, and divides by (n+1)^2 in a
// restoring divider that yields one quotient bit a cycle, rounding half away from zero.
// A pass-through sample is read in S_RD and loaded into the output register in S_LD; on
// frame_end the held samples are flushed the same way. The input is taken only between
// items, but the next item may enter while the previous result still waits in the output
// register.
// Writing half_width discards a partial frame; write it only while the block is idle.
`default_nettype none

module triangular_fir_smoother_top
    import tfs_pkg::*;
#(
    parameter int MAX_HALF_WIDTH = 15,
    parameter int SAMPLE_BITS    = 16
)(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [HALF_WIDTH_BITS-1:0] cfg_wr_data,
    tfs_in_if.sink                          in_stream,
    tfs_out_if.source                       out_stream
);

    localparam int HIST_DEPTH = 2 * MAX_HALF_WIDTH + 1;
    localparam int AW         = $clog2(HIST_DEPTH);
    localparam int BUF_DEPTH  = 1 << AW;
    localparam int PW         = $clog2(HIST_DEPTH + 1);
    localparam int NW         = $clog2(MAX_HALF_WIDTH + 1);
    localparam int WW         = $clog2(MAX_HALF_WIDTH + 2);
    localparam int DW         = 2 * WW;
    localparam int ACC_W      = SAMPLE_BITS + 2 * WW + 1;
    localparam int NUM_W      = ACC_W + 1;
    localparam int CW         = $clog2(SAMPLE_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_MAC_END,
        S_DIV_SETUP,
        S_DIV,
        S_DIV_OUT,
        S_RD,
        S_LD
    } state_t;

    state_t                     state_reg;
    logic [HALF_WIDTH_BITS-1:0] hw_reg;
    logic [PW-1:0]              fpos_reg;
    logic [AW-1:0]              wp_reg;
    logic                       end_reg;
    logic                       center_reg;
    logic [NW-1:0]              flush_reg;
    logic [AW-1:0]              j_reg;
    logic [WW-1:0]              w_d_reg;
    logic                       mac_vld_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [NUM_W-1:0]           rem_reg;
    logic [NUM_W-1:0]           dsh_reg;
    logic [SAMPLE_BITS-1:0]     q_reg;
    logic                       neg_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       out_valid_reg;
    logic [SAMPLE_BITS-1:0]     out_sample_reg;
    logic                       out_last_reg;
    logic [SAMPLE_BITS-1:0]     rdata_reg;

    logic [SAMPLE_BITS-1:0]     hist_mem [BUF_DEPTH];

    logic                       in_ready;
    logic                       in_acc;
    logic [NW-1:0]              n_eff;
    logic                       p_ge_n;
    logic                       p_ge_2n;
    logic [NW-1:0]              rest;
    logic [PW-1:0]              fpos_inc;
    logic [AW-1:0]              k_sel;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              n_addr;
    logic [AW-1:0]              tap_off;
    logic [WW-1:0]              weight;
    logic signed [SAMPLE_BITS+WW:0] prod;
    logic [WW-1:0]              np1;
    logic [DW-1:0]              d_val;
    logic [ACC_W-1:0]           mag;
    logic                       div_ge;
    logic [SAMPLE_BITS-1:0]     q_signed;
    logic                       mac_last;

    assign in_ready        = (state_reg == S_IDLE);
    assign in_acc          = in_stream.valid && in_ready;
    assign in_stream.ready = in_ready;

    assign out_stream.valid      = out_valid_reg;
    assign out_stream.sample_out = out_sample_reg;
    assign out_stream.last_out   = out_last_reg;

    // Register values above the supported width clamp to the largest window.
    always_comb
    begin
        if (32'(hw_reg) > MAX_HALF_WIDTH)
            n_eff = NW'(MAX_HALF_WIDTH);
        else
            n_eff = NW'(hw_reg);
    end

    assign p_ge_n   = int'(fpos_reg) >= int'(n_eff);
    assign p_ge_2n  = int'(fpos_reg) >= 2 * int'(n_eff);
    assign rest     = p_ge_n ? n_eff : NW'(fpos_reg) + NW'(1);
    assign fpos_inc = (int'(fpos_reg) < HIST_DEPTH) ? fpos_reg + PW'(1) : fpos_reg;

    // History index k means the sample k places before the newest one.
    assign n_addr  = AW'(n_eff);
    assign k_sel   = center_reg ? n_addr : AW'(flush_reg - NW'(1));
    assign rd_addr = wp_reg - ((state_reg == S_MAC) ? j_reg : k_sel);
    assign wr_addr = wp_reg + AW'(1);

    assign tap_off  = (j_reg > n_addr) ? j_reg - n_addr : n_addr - j_reg;
    assign weight   = WW'(n_eff) + WW'(1) - WW'(tap_off);
    assign mac_last = (j_reg == AW'(2 * int'(n_eff)));
    assign prod     = $signed(rdata_reg) * $signed({1'b0, w_d_reg});

    assign np1    = WW'(n_eff) + WW'(1);
    assign d_val  = DW'(np1) * DW'(np1);
    assign mag    = acc_reg[ACC_W-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);
    assign div_ge = (rem_reg >= dsh_reg);
    assign q_signed = neg_reg ? SAMPLE_BITS'(0) - q_reg : q_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            hist_mem[wr_addr] <= in_stream.sample_in;
        end
        rdata_reg <= hist_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hw_reg         <= HALF_WIDTH_RESET;
            fpos_reg       <= '0;
            wp_reg         <= '0;
            end_reg        <= 1'b0;
            center_reg     <= 1'b0;
            flush_reg      <= '0;
            j_reg          <= '0;
            w_d_reg        <= '0;
            mac_vld_reg    <= 1'b0;
            acc_reg        <= '0;
            rem_reg        <= '0;
            dsh_reg        <= '0;
            q_reg          <= '0;
            neg_reg        <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_sample_reg <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            mac_vld_reg <= 1'b0;
            if (mac_vld_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod);
            end
            if (out_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        wp_reg    <= wp_reg + AW'(1);
                        end_reg   <= in_stream.frame_end;
                        flush_reg <= in_stream.frame_end ? rest : '0;
                        acc_reg   <= '0;
                        j_reg     <= '0;
                        fpos_reg  <= in_stream.frame_end ? '0 : fpos_inc;
                        if (p_ge_2n && (n_eff != '0))
                        begin
                            center_reg <= 1'b0;
                            state_reg  <= S_MAC;
                        end
                        else if (p_ge_n)
                        begin
                            // Zero width, or one of the first n samples of a frame, which passes through.
                            center_reg <= 1'b1;
                            state_reg  <= S_RD;
                        end
                        else if (in_stream.frame_end)
                        begin
                            center_reg <= 1'b0;
                            state_reg  <= S_RD;
                        end
                    end
                end
                S_MAC:
                begin
                    w_d_reg     <= weight;
                    mac_vld_reg <= 1'b1;
                    if (mac_last)
                        state_reg <= S_MAC_END;
                    else
                        j_reg <= j_reg + AW'(1);
                end
                S_MAC_END:
                begin
                    state_reg <= S_DIV_SETUP;
                end
                S_DIV_SETUP:
                begin
                    // Rounded quotient is floor((2|acc| + d) / 2d).
                    neg_reg   <= acc_reg[ACC_W-1];
                    rem_reg   <= NUM_W'({mag, 1'b0}) + NUM_W'(d_val);
                    dsh_reg   <= NUM_W'({d_val, 1'b0}) << (SAMPLE_BITS - 1);
                    q_reg     <= '0;
                    cnt_reg   <= CW'(SAMPLE_BITS - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_ge)
                    begin
                        rem_reg <= rem_reg - dsh_reg;
                    end
                    q_reg   <= {q_reg[SAMPLE_BITS-2:0], div_ge};
                    dsh_reg <= dsh_reg >> 1;
                    if (cnt_reg == '0)
                        state_reg <= S_DIV_OUT;
                    else
                        cnt_reg <= cnt_reg - CW'(1);
                end
                S_DIV_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_sample_reg <= q_signed;
                        out_last_reg   <= 1'b0;
                        state_reg      <= (end_reg && (flush_reg != '0)) ? S_RD : S_IDLE;
                    end
                end
                S_RD:
                begin
                    // The read is issued here; the data lands in S_LD.
                    if (!out_valid_reg)
                    begin
                        state_reg <= S_LD;
                    end
                end
                S_LD:
                begin
                    out_valid_reg  <= 1'b1;
                    out_sample_reg <= rdata_reg;
                    if (center_reg)
                    begin
                        out_last_reg <= end_reg && (n_eff == '0);
                        center_reg   <= 1'b0;
                        state_reg    <= (end_reg && (flush_reg != '0)) ? S_RD : S_IDLE;
                    end
                    else
                    begin
                        out_last_reg <= (flush_reg == NW'(1));
                        flush_reg    <= flush_reg - NW'(1);
                        state_reg    <= (flush_reg != NW'(1)) ? S_RD : S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cfg_wr_en)
            begin
                hw_reg   <= cfg_wr_data;
                fpos_reg <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tfs_checker.sv =====
// Port-level checker for the triangular FIR smoother, bound to the top level.
`default_nettype none

`include "triangular_fir_smoother_top_macros.svh"

module tfs_checker
    import tfs_pkg::*;
#(
    parameter int MAX_HALF_WIDTH = 15
)(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic                       cfg_wr_en,
    input wire logic [HALF_WIDTH_BITS-1:0] cfg_wr_data
);

    localparam int BW = $clog2(MAX_HALF_WIDTH + 4) + 1;

    // Samples taken in but not yet returned; a width write drops the held ones.
    logic [BW-1:0] bal_reg;
    logic          in_xfer;
    logic          out_xfer;
    logic          cfg_seen_reg;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bal_reg      <= '0;
            cfg_seen_reg <= 1'b0;
        end
        else
        begin
            cfg_seen_reg <= cfg_wr_en && (cfg_wr_data != '0);
            if (cfg_wr_en)
                bal_reg <= '0;
            else
                bal_reg <= bal_reg + BW'(in_xfer) - BW'(out_xfer);
        end
    end

    `TFS_ASSERT_NEXT(a_out_valid_hold, clk, rst_n, out_valid && !out_ready, out_valid, "output valid dropped before its transfer")
    `TFS_ASSERT_SAME(a_no_invented_result, clk, rst_n, out_xfer, (bal_reg != '0) || cfg_seen_reg || !cfg_seen_reg && (bal_reg != '0), "result transferred with no sample outstanding")
    `TFS_ASSERT_SAME(a_held_bound, clk, rst_n, 1'b1, int'(bal_reg) <= MAX_HALF_WIDTH + 2, "more samples outstanding than the window can hold")

endmodule

bind triangular_fir_smoother_top tfs_checker #(
    .MAX_HALF_WIDTH(MAX_HALF_WIDTH)
) u_tfs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_stream.valid),
    .in_ready   (in_stream.ready),
    .out_valid  (out_stream.valid),
    .out_ready  (out_stream.ready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
);

`default_nettype wire
